@@ hdl/dgr_pkg.sv @@
// Package with shared constants, types and field layouts of the DDA grid raycaster.
`default_nettype none
package dgr_pkg;
    localparam int MapBits = 6;
    localparam int MapSize = 64;
    localparam int FracBits = 16;
    localparam int ScreenHeight = 512;
    localparam int MaxSteps = 2 * MapSize;
    localparam logic [31:0] DeltaMax = 32'd2147483647;
    localparam logic [31:0] U32Max = 32'hFFFF_FFFF;
    localparam logic [7:0] CharWallA = 8'h31;
    localparam logic [7:0] CharWallB = 8'h32;
    localparam logic ActWrite = 1'b0;
    localparam logic ActCast = 1'b1;
    // Divider request and answer between the sequencer and the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;
    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

@@ hdl/dgr_divider.sv @@
// Shared restoring divider for 64-bit operands, one quotient bit per cycle.
`default_nettype none
module dgr_divider (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dgr_pkg::div_req_t req,
    output dgr_pkg::div_rsp_t     rsp
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] trial;

    always_comb begin
        shifted = {rem_reg, quo_reg[63]};
        trial = shifted - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

@@ hdl/dda_grid_raycaster_top.sv @@
// Top level of the DDA grid raycaster: map memory, ray sequencer and result register.
// A map write is stored when its transfer is accepted. A cast runs the two reciprocals,
// a grid walk of up to 128 steps and the line height division; all three divisions use
// the shared 64-bit bit-serial divider.
// One item is worked on at a time; s_axis_tready is high only while the sequencer idles.
// aresetn is synchronous and active low; it clears control state, not the map memory.
`default_nettype none
module dda_grid_raycaster_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, lowest bit up: action, cell_x, cell_y, cell_char, pos_x, pos_y,
    // ray_dir_x, ray_dir_y, then zero padding.
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, lowest bit up: wall_side, hit_x, hit_y, perp_dist, line_height,
    // draw_start, draw_end, no_hit.
    output logic [79:0]       m_axis_tdata
);
    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StDivX  = 4'd1;
    localparam logic [3:0] StWaitX = 4'd2;
    localparam logic [3:0] StDivY  = 4'd3;
    localparam logic [3:0] StWaitY = 4'd4;
    localparam logic [3:0] StSideX = 4'd5;
    localparam logic [3:0] StSideY = 4'd6;
    localparam logic [3:0] StStep  = 4'd7;
    localparam logic [3:0] StTest  = 4'd8;
    localparam logic [3:0] StDivL  = 4'd9;
    localparam logic [3:0] StWaitL = 4'd10;
    localparam logic [3:0] StOut   = 4'd11;

    // Input field split.
    logic        in_action;
    logic [5:0]  in_cx, in_cy;
    logic [7:0]  in_char;
    assign in_action = s_axis_tdata[0];
    assign in_cx = s_axis_tdata[6:1];
    assign in_cy = s_axis_tdata[12:7];
    assign in_char = s_axis_tdata[20:13];

    // The wall map is a 4096 x 1 memory, written by write items and read during the walk.
    logic wall_mem [dgr_pkg::MapSize * dgr_pkg::MapSize];
    logic wall_rd_reg;

    logic [3:0]  state_reg, state_next;
    logic [21:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [17:0] dir_x_reg, dir_x_next, dir_y_reg, dir_y_next;
    logic [5:0]  wcx_reg, wcx_next, wcy_reg, wcy_next;
    logic [31:0] sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [31:0] ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic        side_reg, side_next;
    logic [7:0]  steps_reg, steps_next;
    logic [31:0] perp_reg, perp_next;
    logic        ovf_reg, ovf_next;
    logic        out_valid_reg, out_valid_next;
    logic [79:0] out_data_reg, out_data_next;

    dgr_pkg::div_req_t div_req;
    dgr_pkg::div_rsp_t div_rsp;

    dgr_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // Shared multiplier for the initial side distances: distance times delta.
    // The distance can reach a full 2^22 (last column, position zero), so it keeps 23 bits.
    logic        mul_neg;
    logic [21:0] mul_pos;
    logic [5:0]  mul_cell;
    logic [31:0] mul_delta;
    logic [23:0] mul_base, mul_d_raw;
    logic [22:0] mul_d;
    logic [54:0] mul_prod;
    logic [31:0] mul_sat;

    always_comb begin
        mul_neg = (state_reg == StSideX) ? dir_x_reg[17] : dir_y_reg[17];
        mul_pos = (state_reg == StSideX) ? pos_x_reg : pos_y_reg;
        mul_cell = (state_reg == StSideX) ? wcx_reg : wcy_reg;
        mul_delta = (state_reg == StSideX) ? ddx_reg : ddy_reg;
        mul_base = {2'b0, mul_cell, 16'd0};
        if (mul_neg) begin
            mul_d_raw = {2'b0, mul_pos} - mul_base;
        end else begin
            mul_d_raw = mul_base + 24'(1 << dgr_pkg::FracBits) - {2'b0, mul_pos};
        end
        // A position outside its cell gives a negative distance, taken as zero.
        mul_d = mul_d_raw[23] ? 23'd0 : mul_d_raw[22:0];
        mul_prod = mul_d * mul_delta;
        mul_sat = (|mul_prod[54:48]) ? dgr_pkg::U32Max : mul_prod[47:16];
    end

    // Step candidates.
    logic        take_x;
    logic [32:0] sum_x, sum_y;
    logic [6:0]  nx, ny;
    logic        leave;
    logic [15:0] lh;
    logic [14:0] lh_half;
    logic [8:0]  ds, de;
    logic [15:0] de_full;
    logic [17:0] mag_x, mag_y;

    always_comb begin
        take_x = sdx_reg < sdy_reg;
        sum_x = {1'b0, sdx_reg} + {1'b0, ddx_reg};
        sum_y = {1'b0, sdy_reg} + {1'b0, ddy_reg};
        nx = dir_x_reg[17] ? {1'b0, wcx_reg} - 7'd1 : {1'b0, wcx_reg} + 7'd1;
        ny = dir_y_reg[17] ? {1'b0, wcy_reg} - 7'd1 : {1'b0, wcy_reg} + 7'd1;
        leave = take_x ? nx[6] : ny[6];
        mag_x = dir_x_reg[17] ? 18'(-dir_x_reg) : dir_x_reg;
        mag_y = dir_y_reg[17] ? 18'(-dir_y_reg) : dir_y_reg;
        lh = (ovf_reg || perp_reg == 32'd0 || (|div_rsp.quotient[63:16])) ? 16'hFFFF
             : div_rsp.quotient[15:0];
        lh_half = lh[15:1];
        ds = ({1'b0, lh_half} > 16'(dgr_pkg::ScreenHeight / 2)) ? 9'd0
             : 9'(16'(dgr_pkg::ScreenHeight / 2) - {1'b0, lh_half});
        de_full = {1'b0, lh_half} + 16'(dgr_pkg::ScreenHeight / 2);
        de = (de_full >= 16'(dgr_pkg::ScreenHeight)) ? 9'(dgr_pkg::ScreenHeight - 1)
             : de_full[8:0];
    end

    always_comb begin
        state_next = state_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        dir_x_next = dir_x_reg;
        dir_y_next = dir_y_reg;
        wcx_next = wcx_reg;
        wcy_next = wcy_reg;
        sdx_next = sdx_reg;
        sdy_next = sdy_reg;
        ddx_next = ddx_reg;
        ddy_next = ddy_reg;
        side_next = side_reg;
        steps_next = steps_reg;
        perp_next = perp_reg;
        ovf_next = ovf_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        div_req = '0;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            StIdle: begin
                if (s_axis_tvalid && in_action == dgr_pkg::ActCast) begin
                    wcx_next = in_cx;
                    wcy_next = in_cy;
                    pos_x_next = s_axis_tdata[42:21];
                    pos_y_next = s_axis_tdata[64:43];
                    dir_x_next = s_axis_tdata[82:65];
                    dir_y_next = s_axis_tdata[100:83];
                    steps_next = '0;
                    state_next = StDivX;
                end
            end
            StDivX: begin
                if (dir_x_reg == 18'd0) begin
                    ddx_next = dgr_pkg::DeltaMax;
                    state_next = StDivY;
                end else begin
                    div_req.start = 1'b1;
                    div_req.dividend = 64'd1 << (2 * dgr_pkg::FracBits);
                    div_req.divisor = {46'd0, mag_x};
                    state_next = StWaitX;
                end
            end
            StWaitX: begin
                if (div_rsp.done) begin
                    ddx_next = (div_rsp.quotient > {32'd0, dgr_pkg::DeltaMax})
                               ? dgr_pkg::DeltaMax : div_rsp.quotient[31:0];
                    state_next = StDivY;
                end
            end
            StDivY: begin
                if (dir_y_reg == 18'd0) begin
                    ddy_next = dgr_pkg::DeltaMax;
                    state_next = StSideX;
                end else begin
                    div_req.start = 1'b1;
                    div_req.dividend = 64'd1 << (2 * dgr_pkg::FracBits);
                    div_req.divisor = {46'd0, mag_y};
                    state_next = StWaitY;
                end
            end
            StWaitY: begin
                if (div_rsp.done) begin
                    ddy_next = (div_rsp.quotient > {32'd0, dgr_pkg::DeltaMax})
                               ? dgr_pkg::DeltaMax : div_rsp.quotient[31:0];
                    state_next = StSideX;
                end
            end
            StSideX: begin
                sdx_next = mul_sat;
                state_next = StSideY;
            end
            StSideY: begin
                sdy_next = mul_sat;
                state_next = StStep;
            end
            StStep: begin
                if (steps_reg == 8'(dgr_pkg::MaxSteps) || leave) begin
                    state_next = StOut;
                    ovf_next = 1'b1;
                end else begin
                    steps_next = steps_reg + 8'd1;
                    if (take_x) begin
                        sdx_next = sum_x[32] ? dgr_pkg::U32Max : sum_x[31:0];
                        wcx_next = nx[5:0];
                        side_next = 1'b0;
                    end else begin
                        sdy_next = sum_y[32] ? dgr_pkg::U32Max : sum_y[31:0];
                        wcy_next = ny[5:0];
                        side_next = 1'b1;
                    end
                    state_next = StTest;
                end
            end
            StTest: begin
                if (wall_rd_reg) begin
                    perp_next = side_reg ? sdy_reg - ddy_reg : sdx_reg - ddx_reg;
                    ovf_next = 1'b0;
                    state_next = StDivL;
                end else begin
                    state_next = StStep;
                end
            end
            StDivL: begin
                if (perp_reg == 32'd0) begin
                    state_next = StOut;
                end else begin
                    div_req.start = 1'b1;
                    div_req.dividend = 64'(3 * dgr_pkg::ScreenHeight) << dgr_pkg::FracBits;
                    div_req.divisor = {31'd0, perp_reg, 1'b0};
                    state_next = StWaitL;
                end
            end
            StWaitL: begin
                if (div_rsp.done) begin
                    state_next = StOut;
                end
            end
            StOut: begin
                // ovf_reg set here marks a walk that found no wall.
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    if (ovf_reg) begin
                        out_data_next = 80'd1 << 79;
                    end else begin
                        out_data_next = {1'b0, de, ds, lh, perp_reg, wcy_reg, wcx_reg,
                                         side_reg};
                    end
                    ovf_next = 1'b0;
                    state_next = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
            out_valid_reg <= 1'b0;
            ovf_reg <= 1'b0;
            wcx_reg <= '0;
            wcy_reg <= '0;
            sdx_reg <= '0;
            sdy_reg <= '0;
            ddx_reg <= '0;
            ddy_reg <= '0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            ovf_reg <= ovf_next;
            wcx_reg <= wcx_next;
            wcy_reg <= wcy_next;
            sdx_reg <= sdx_next;
            sdy_reg <= sdy_next;
            ddx_reg <= ddx_next;
            ddy_reg <= ddy_next;
        end
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        dir_x_reg <= dir_x_next;
        dir_y_reg <= dir_y_next;
        side_reg <= side_next;
        steps_reg <= steps_next;
        perp_reg <= perp_next;
        out_data_reg <= out_data_next;
    end

    // Map port: the write comes from the input transfer, the read follows each step.
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready && in_action == dgr_pkg::ActWrite) begin
            wall_mem[{in_cx, in_cy}] <= (in_char == dgr_pkg::CharWallA)
                                     || (in_char == dgr_pkg::CharWallB);
        end
        wall_rd_reg <= wall_mem[{wcx_next, wcy_next}];
    end

    assign s_axis_tready = (state_reg == StIdle);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
endmodule
`default_nettype wire

@@ hdl/dgr_checker.sv @@
// Port checker for the DDA grid raycaster, bound to the top level.
`default_nettype none
module dgr_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [103:0] s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [79:0]  m_axis_tdata
);
    // A stalled result holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // A cast transfer makes the block busy in the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
        else $error("ready after cast");
    // A no_hit result carries zero in every other field.
    a_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[79] |-> m_axis_tdata[78:0] == 79'd0)
        else $error("no_hit result not cleared");
    // A write transfer never produces a result in the next cycle.
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !s_axis_tdata[0] && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result after write");
endmodule

bind dda_grid_raycaster_top dgr_checker u_dgr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
